@@ rtl/core/lazy_range_add_range_sum_tree_assert.svh @@
// assertion macros used by the lazy range tree rtl
`ifndef LAZY_RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH
`define LAZY_RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LRST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lrst assertion failed");
`define LRST_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lrst assertion failed");
`else
`define LRST_ASSERT(lbl, clk, rst_n, prop)
`define LRST_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/core/lrst_pkg.sv @@
// types, constants and helpers of the lazy range add / range sum tree
`default_nettype none
package lrst_pkg;

    localparam int LEAVES  = 1024;
    localparam int LG      = $clog2(LEAVES);
    localparam int NODES   = 2 * LEAVES;
    localparam int NODE_W  = LG + 1;
    localparam int BND_W   = LG + 2;
    localparam int WT_W    = LG + 1;
    localparam int LVL_W   = $clog2(LG + 1);
    localparam int VAL_W   = 64;
    localparam int OPC_W   = 3;
    localparam int LEFT_W  = LG;
    localparam int RIGHT_W = LG + 1;

    localparam logic [BND_W-1:0] LEAVES_B = BND_W'(LEAVES);

    typedef enum logic [OPC_W-1:0] {
        OPC_SET  = 3'd0,
        OPC_ADD  = 3'd1,
        OPC_READ = 3'd2,
        OPC_SUM  = 3'd3,
        OPC_RADD = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [OPC_W-1:0]   opcode;
        logic [LEFT_W-1:0]  left_index;
        logic [RIGHT_W-1:0] right_index;
        logic signed [VAL_W-1:0] value;
        logic               weight;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] sum_value;
        logic [WT_W-1:0]         sum_weight;
    } t_out_item;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ADDEND,
        ACT_MUL,
        ACT_TAG,
        ACT_PCLR,
        ACT_LATCH,
        ACT_PULL,
        ACT_SET,
        ACT_ADDLEAF,
        ACT_ACC,
        ACT_EMIT,
        ACT_INIT
    } t_act;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic [NODE_W-1:0] wr_addr;
        t_act              act;
        logic              use_val;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    // reset weight of node k: leaves 1, internal nodes their leaf count
    function automatic logic [WT_W-1:0] init_weight(input logic [NODE_W-1:0] k);
        logic [WT_W-1:0] w;
        w = '0;
        for (int d = 0; d < NODE_W; d++) begin
            if (k[d]) begin
                w = WT_W'(LEAVES >> d);
            end
        end
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/lrst_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none
module lrst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/core/lrst_ctrl.sv @@
// sequencer for push-down, range walk and pull-up over the node memories
`default_nettype none
`include "lazy_range_add_range_sum_tree_assert.svh"
module lrst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lrst_pkg::t_in_item i_in_data,
    input  lrst_pkg::t_stat   i_stat,
    output lrst_pkg::t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PCHK, S_PD1, S_PD2, S_PD3, S_PD4, S_PD5, S_PD6,
        S_ACT, S_LEAF_ADD, S_LA, S_LB, S_LSH, S_N1, S_N2,
        S_UCHK, S_PU1, S_PU2, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic [lrst_pkg::OPC_W-1:0]  r_op, n_op;
    logic [lrst_pkg::BND_W-1:0]  r_l, n_l, r_r, n_r, r_a, n_a, r_b, n_b;
    logic [lrst_pkg::LVL_W-1:0]  r_lvl, n_lvl;
    logic                        r_side, n_side;
    logic [lrst_pkg::NODE_W-1:0] r_node, n_node, r_clr, n_clr;

    logic [lrst_pkg::BND_W-1:0]  w_base, w_edge, w_mask, w_shift, w_lft, w_rgt, w_bm1;
    logic [lrst_pkg::NODE_W-1:0] w_tgt, w_tgt2;
    logic                        w_cond;
    lrst_pkg::t_cmd              w_cmd;

    // node on the left or right boundary path at the current level
    assign w_base  = r_side ? (r_r - lrst_pkg::BND_W'(1)) : r_l;
    assign w_edge  = r_side ? r_r : r_l;
    assign w_mask  = ~({lrst_pkg::BND_W{1'b1}} << r_lvl);
    assign w_cond  = |(w_edge & w_mask);
    assign w_shift = w_base >> r_lvl;
    assign w_tgt   = w_shift[lrst_pkg::NODE_W-1:0];
    assign w_tgt2  = {w_tgt[lrst_pkg::NODE_W-2:0], 1'b0};
    assign w_bm1   = r_b - lrst_pkg::BND_W'(1);

    assign w_lft = lrst_pkg::BND_W'(i_in_data.left_index);
    assign w_rgt = (lrst_pkg::BND_W'(i_in_data.right_index) > lrst_pkg::LEAVES_B)
                 ? lrst_pkg::LEAVES_B : lrst_pkg::BND_W'(i_in_data.right_index);

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = w_cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_l     = r_l;
        n_r     = r_r;
        n_a     = r_a;
        n_b     = r_b;
        n_lvl   = r_lvl;
        n_side  = r_side;
        n_node  = r_node;
        n_clr   = r_clr;
        w_cmd   = '{rd_en: 1'b0, rd_addr: '0, wr_addr: '0,
                    act: lrst_pkg::ACT_NONE, use_val: 1'b0};
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.act     = lrst_pkg::ACT_INIT;
                w_cmd.wr_addr = r_clr;
                n_clr         = r_clr + lrst_pkg::NODE_W'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.act = lrst_pkg::ACT_LOAD;
                    n_op      = i_in_data.opcode;
                    n_lvl     = lrst_pkg::LVL_W'(lrst_pkg::LG);
                    n_side    = 1'b0;
                    case (i_in_data.opcode) inside
                        lrst_pkg::OPC_SET, lrst_pkg::OPC_ADD, lrst_pkg::OPC_READ: begin
                            if (w_lft < lrst_pkg::LEAVES_B) begin
                                n_l     = w_lft + lrst_pkg::LEAVES_B;
                                n_r     = w_lft + lrst_pkg::LEAVES_B + lrst_pkg::BND_W'(1);
                                n_state = S_PCHK;
                            end else if (i_in_data.opcode == lrst_pkg::OPC_READ) begin
                                n_state = S_EMIT;
                            end
                        end
                        lrst_pkg::OPC_SUM, lrst_pkg::OPC_RADD: begin
                            if (w_lft < w_rgt) begin
                                n_l     = w_lft + lrst_pkg::LEAVES_B;
                                n_r     = w_rgt + lrst_pkg::LEAVES_B;
                                n_state = S_PCHK;
                            end else if (i_in_data.opcode == lrst_pkg::OPC_SUM) begin
                                n_state = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PCHK, S_PD6: begin
                if (r_state == S_PD6 || !w_cond) begin
                    if (r_state == S_PD6) begin
                        w_cmd.act     = lrst_pkg::ACT_PCLR;
                        w_cmd.wr_addr = r_node;
                    end
                    if (r_side) begin
                        if (r_lvl == lrst_pkg::LVL_W'(1)) begin
                            n_state = S_ACT;
                        end else begin
                            n_side  = 1'b0;
                            n_lvl   = r_lvl - lrst_pkg::LVL_W'(1);
                            n_state = S_PCHK;
                        end
                    end else begin
                        n_side  = 1'b1;
                        n_state = S_PCHK;
                    end
                end else begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = w_tgt;
                    n_node        = w_tgt;
                    n_state       = S_PD1;
                end
            end
            S_PD1: begin
                w_cmd.act     = lrst_pkg::ACT_ADDEND;
                w_cmd.rd_en   = 1'b1;
                w_cmd.rd_addr = {r_node[lrst_pkg::NODE_W-2:0], 1'b0};
                n_state       = S_PD2;
            end
            S_PD2: begin
                w_cmd.act = lrst_pkg::ACT_MUL;
                n_state   = S_PD3;
            end
            S_PD3: begin
                w_cmd.act     = lrst_pkg::ACT_TAG;
                w_cmd.wr_addr = {r_node[lrst_pkg::NODE_W-2:0], 1'b0};
                w_cmd.rd_en   = 1'b1;
                w_cmd.rd_addr = {r_node[lrst_pkg::NODE_W-2:0], 1'b1};
                n_state       = S_PD4;
            end
            S_PD4: begin
                w_cmd.act = lrst_pkg::ACT_MUL;
                n_state   = S_PD5;
            end
            S_PD5: begin
                w_cmd.act     = lrst_pkg::ACT_TAG;
                w_cmd.wr_addr = {r_node[lrst_pkg::NODE_W-2:0], 1'b1};
                n_state       = S_PD6;
            end
            S_ACT: begin
                case (r_op) inside
                    lrst_pkg::OPC_SET: begin
                        w_cmd.act     = lrst_pkg::ACT_SET;
                        w_cmd.wr_addr = r_l[lrst_pkg::NODE_W-1:0];
                        n_lvl         = lrst_pkg::LVL_W'(1);
                        n_side        = 1'b0;
                        n_state       = S_UCHK;
                    end
                    lrst_pkg::OPC_ADD: begin
                        w_cmd.rd_en   = 1'b1;
                        w_cmd.rd_addr = r_l[lrst_pkg::NODE_W-1:0];
                        n_state       = S_LEAF_ADD;
                    end
                    default: begin
                        // a point read walks the range of one leaf
                        n_a     = r_l;
                        n_b     = r_r;
                        n_state = S_LA;
                    end
                endcase
            end
            S_LEAF_ADD: begin
                w_cmd.act     = lrst_pkg::ACT_ADDLEAF;
                w_cmd.wr_addr = r_l[lrst_pkg::NODE_W-1:0];
                n_lvl         = lrst_pkg::LVL_W'(1);
                n_side        = 1'b0;
                n_state       = S_UCHK;
            end
            S_LA: begin
                if (r_a >= r_b) begin
                    if (r_op == lrst_pkg::OPC_RADD) begin
                        n_lvl   = lrst_pkg::LVL_W'(1);
                        n_side  = 1'b0;
                        n_state = S_UCHK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else if (r_a[0]) begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = r_a[lrst_pkg::NODE_W-1:0];
                    n_node        = r_a[lrst_pkg::NODE_W-1:0];
                    n_a           = r_a + lrst_pkg::BND_W'(1);
                    n_side        = 1'b0;
                    n_state       = S_N1;
                end else begin
                    n_state = S_LB;
                end
            end
            S_LB: begin
                if (r_b[0]) begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = w_bm1[lrst_pkg::NODE_W-1:0];
                    n_node        = w_bm1[lrst_pkg::NODE_W-1:0];
                    n_b           = w_bm1;
                    n_side        = 1'b1;
                    n_state       = S_N1;
                end else begin
                    n_state = S_LSH;
                end
            end
            S_LSH: begin
                n_a     = r_a >> 1;
                n_b     = r_b >> 1;
                n_state = S_LA;
            end
            S_N1: begin
                if (r_op == lrst_pkg::OPC_RADD) begin
                    w_cmd.act     = lrst_pkg::ACT_MUL;
                    w_cmd.use_val = 1'b1;
                    n_state       = S_N2;
                end else begin
                    w_cmd.act = lrst_pkg::ACT_ACC;
                    n_state   = r_side ? S_LSH : S_LB;
                end
            end
            S_N2: begin
                w_cmd.act     = lrst_pkg::ACT_TAG;
                w_cmd.wr_addr = r_node;
                n_state       = r_side ? S_LSH : S_LB;
            end
            S_UCHK, S_PU2: begin
                if (r_state == S_PU2 || !w_cond) begin
                    if (r_state == S_PU2) begin
                        w_cmd.act     = lrst_pkg::ACT_PULL;
                        w_cmd.wr_addr = r_node;
                    end
                    if (r_side) begin
                        if (r_lvl == lrst_pkg::LVL_W'(lrst_pkg::LG)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_side  = 1'b0;
                            n_lvl   = r_lvl + lrst_pkg::LVL_W'(1);
                            n_state = S_UCHK;
                        end
                    end else begin
                        n_side  = 1'b1;
                        n_state = S_UCHK;
                    end
                end else begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = w_tgt2;
                    n_node        = w_tgt;
                    n_state       = S_PU1;
                end
            end
            S_PU1: begin
                w_cmd.act     = lrst_pkg::ACT_LATCH;
                w_cmd.rd_en   = 1'b1;
                w_cmd.rd_addr = {r_node[lrst_pkg::NODE_W-2:0], 1'b1};
                n_state       = S_PU2;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    w_cmd.act = lrst_pkg::ACT_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_op    <= '0;
            r_lvl   <= '0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_op    <= n_op;
            r_lvl   <= n_lvl;
            r_side  <= n_side;
        end
        r_l    <= n_l;
        r_r    <= n_r;
        r_a    <= n_a;
        r_b    <= n_b;
        r_node <= n_node;
    end

    `LRST_ASSERT(a_emit_free, i_clk, i_rst_n, (o_cmd.act == lrst_pkg::ACT_EMIT) |-> i_stat.out_free)
    `LRST_ASSERT(a_push_internal, i_clk, i_rst_n, (r_state == S_PD1) |-> (r_node != '0 && !r_node[lrst_pkg::NODE_W-1]))
    `LRST_ASSERT(a_clear_runs, i_clk, i_rst_n, (r_state == S_CLEAR && !(&r_clr)) |=> (r_state == S_CLEAR))
endmodule
`default_nettype wire

@@ rtl/core/lrst_dpath.sv @@
// node memories, multiply-add unit, accumulators and output register
`default_nettype none
module lrst_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrst_pkg::t_cmd     i_cmd,
    input  lrst_pkg::t_in_item i_in_data,
    output lrst_pkg::t_stat    o_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lrst_pkg::t_out_item o_out_data
);
    logic [lrst_pkg::VAL_W-1:0] w_s_q, w_p_q, w_s_wd, w_p_wd, w_addsel;
    logic [lrst_pkg::WT_W-1:0]  w_w_q, w_w_wd;
    logic                       w_s_we, w_w_we, w_p_we;

    logic [lrst_pkg::VAL_W-1:0] r_val, r_add, r_tadd, r_prod, r_s, r_p, r_sv;
    logic [lrst_pkg::WT_W-1:0]  r_w, r_sw;
    logic                       r_wt, r_out_valid;
    lrst_pkg::t_out_item        r_out;

    lrst_ram #(.WIDTH(lrst_pkg::VAL_W), .DEPTH(lrst_pkg::NODES)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (w_s_wd),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_s_q)
    );

    lrst_ram #(.WIDTH(lrst_pkg::WT_W), .DEPTH(lrst_pkg::NODES)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (w_w_we),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (w_w_wd),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_w_q)
    );

    // pending tags exist only for internal nodes
    lrst_ram #(.WIDTH(lrst_pkg::VAL_W), .DEPTH(lrst_pkg::LEAVES)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (i_cmd.wr_addr[lrst_pkg::LG-1:0]),
        .i_wdata (w_p_wd),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr[lrst_pkg::LG-1:0]),
        .o_rdata (w_p_q)
    );

    assign w_addsel = i_cmd.use_val ? r_val : r_add;

    always_comb begin
        w_s_we = 1'b0;
        w_w_we = 1'b0;
        w_p_we = 1'b0;
        w_s_wd = '0;
        w_w_wd = '0;
        w_p_wd = '0;
        case (i_cmd.act)
            lrst_pkg::ACT_TAG: begin
                w_s_we = 1'b1;
                w_s_wd = r_s + r_prod;
                w_p_we = !i_cmd.wr_addr[lrst_pkg::NODE_W-1];
                w_p_wd = r_p + r_tadd;
            end
            lrst_pkg::ACT_PCLR: begin
                w_p_we = 1'b1;
            end
            lrst_pkg::ACT_PULL: begin
                w_s_we = 1'b1;
                w_w_we = 1'b1;
                w_s_wd = r_s + w_s_q;
                w_w_wd = r_w + w_w_q;
            end
            lrst_pkg::ACT_SET: begin
                w_s_we = 1'b1;
                w_w_we = 1'b1;
                w_s_wd = r_val;
                w_w_wd = lrst_pkg::WT_W'(r_wt);
            end
            lrst_pkg::ACT_ADDLEAF: begin
                w_s_we = 1'b1;
                w_w_we = 1'b1;
                w_s_wd = w_s_q + r_val;
                w_w_wd = lrst_pkg::WT_W'(1);
            end
            lrst_pkg::ACT_INIT: begin
                w_s_we = 1'b1;
                w_w_we = 1'b1;
                w_w_wd = lrst_pkg::init_weight(i_cmd.wr_addr);
                w_p_we = !i_cmd.wr_addr[lrst_pkg::NODE_W-1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            lrst_pkg::ACT_LOAD: begin
                r_val <= $unsigned(i_in_data.value);
                r_wt  <= i_in_data.weight;
                r_sv  <= '0;
                r_sw  <= '0;
            end
            lrst_pkg::ACT_ADDEND: begin
                r_add <= w_p_q;
            end
            lrst_pkg::ACT_MUL: begin
                // addend times subtree weight, wraps mod 2^64
                r_prod <= w_addsel * lrst_pkg::VAL_W'(w_w_q);
                r_tadd <= w_addsel;
                r_s    <= w_s_q;
                r_p    <= w_p_q;
            end
            lrst_pkg::ACT_LATCH: begin
                r_s <= w_s_q;
                r_w <= w_w_q;
            end
            lrst_pkg::ACT_ACC: begin
                r_sv <= r_sv + w_s_q;
                r_sw <= r_sw + w_w_q;
            end
            lrst_pkg::ACT_EMIT: begin
                r_out.sum_value  <= $signed(r_sv);
                r_out.sum_weight <= r_sw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.act == lrst_pkg::ACT_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
endmodule
`default_nettype wire

@@ rtl/core/lazy_range_add_range_sum_tree.sv @@
// Lazy segment tree over 1024 leaves with range add and range sum. One item
// is taken at a time: after it is accepted the block walks the two boundary
// paths pushing pending tags down (up to 20 nodes), then updates or sums the
// covering nodes, then pulls sums back up for updates; the time an item takes
// is set by the single read port of the node memories.
// A read or range sum yields one result beat; a result waiting in the output
// register does not block the next input beat. After reset a clearing pass
// writes each of the 2048 nodes to initialize the node memories before the
// first input beat.
`default_nettype none
module lazy_range_add_range_sum_tree (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lrst_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lrst_pkg::t_out_item o_out_data
);
    lrst_pkg::t_cmd  w_cmd;
    lrst_pkg::t_stat w_stat;

    lrst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lrst_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire
